// File: rtl/core/cht_pkg.sv
package cht_pkg;

  // fixed field widths of the stream words
  localparam int unsigned CmdW    = 2;
  localparam int unsigned KeyW    = 20;
  localparam int unsigned DataW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned BucketW = 6;
  localparam int unsigned CountW  = 7;

  // packed stream words, padded to whole bytes
  localparam int unsigned SDataW = 56;
  localparam int unsigned MDataW = 40;

  // bucket table size, tied to the bucket field width
  localparam int unsigned MaxBuckets = 64;

  // golden ratio constant with six decimal places
  localparam logic [KeyW-1:0] HashMult  = 20'd618033;
  localparam logic [KeyW-1:0] HashScale = 20'd1000000;

  // 1024 * HashMult mod HashScale, folds the upper half of the key
  localparam logic [KeyW-1:0] HashFold = 20'd865792;

  // reciprocals of the scale: floor(x / scale) = (x * recip) >> shift
  localparam logic [31:0] SumRecip   = 32'd2251799814;  // x below 2^31
  localparam int unsigned SumShift   = 51;
  localparam logic [31:0] ScaleRecip = 32'd70368745;    // x below 2^26
  localparam int unsigned ScaleShift = 46;

  localparam logic [CountW-1:0] CountReset = 7'd40;

  typedef enum logic [CmdW-1:0] {
    CmdClear  = 2'd0,
    CmdInsert = 2'd1,
    CmdSearch = 2'd2
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StatusOk   = 2'd0,
    StatusMiss = 2'd1,
    StatusFull = 2'd2
  } status_e;

  typedef struct packed {
    logic              start;
    logic [KeyW-1:0]   key;
    logic [CountW-1:0] count;
  } hash_req_t;

  typedef struct packed {
    logic               done;
    logic [BucketW-1:0] bucket;
  } hash_rsp_t;

endpackage

// File: rtl/core/cht_ram.sv
module cht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/cht_hash_unit.sv
module cht_hash_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cht_pkg::hash_req_t req_i,
  output cht_pkg::hash_rsp_t rsp_o
);

  localparam int unsigned KeyW    = cht_pkg::KeyW;
  localparam int unsigned BucketW = cht_pkg::BucketW;
  localparam int unsigned CountW  = cht_pkg::CountW;
  localparam int unsigned HalfW   = KeyW / 2;
  localparam int unsigned OpW     = 32;
  localparam int unsigned ProdW   = 2 * OpW;
  // quotient of the key sum by the scale stays below 2^11
  localparam int unsigned QuoW    = 11;

  typedef enum logic [2:0] {
    StIdle,
    StSumHi,   // upper key half times the folded constant
    StSumLo,   // add lower key half times the constant
    StQuot,    // sum divided by the scale, via reciprocal
    StFrac,    // sum minus quotient times scale
    StScale,   // fraction times bucket count
    StBucket   // scaled fraction divided by the scale
  } state_e;

  state_e             state_q;
  logic [KeyW-1:0]    key_q;
  logic [CountW-1:0]  m_q;
  logic [OpW-1:0]     acc_q;
  logic [QuoW-1:0]    quo_q;
  logic               done_q;
  logic [BucketW-1:0] bucket_q;

  logic [OpW-1:0]    op_a;
  logic [OpW-1:0]    op_b;
  logic [ProdW-1:0]  prod;
  logic [CountW-1:0] m_clamp;

  // operand select for the shared multiplier
  always_comb begin
    unique case (state_q)
      StSumHi: begin
        op_a = OpW'(key_q[KeyW-1:HalfW]);
        op_b = OpW'(cht_pkg::HashFold);
      end
      StSumLo: begin
        op_a = OpW'(key_q[HalfW-1:0]);
        op_b = OpW'(cht_pkg::HashMult);
      end
      StQuot: begin
        op_a = acc_q;
        op_b = cht_pkg::SumRecip;
      end
      StFrac: begin
        op_a = OpW'(quo_q);
        op_b = OpW'(cht_pkg::HashScale);
      end
      StScale: begin
        op_a = acc_q;
        op_b = OpW'(m_q);
      end
      StBucket: begin
        op_a = acc_q;
        op_b = cht_pkg::ScaleRecip;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // shared multiplier
  assign prod = ProdW'(op_a) * ProdW'(op_b);

  always_comb begin
    if (req_i.count == '0) begin
      m_clamp = CountW'(1);
    end else if (req_i.count > CountW'(cht_pkg::MaxBuckets)) begin
      m_clamp = CountW'(cht_pkg::MaxBuckets);
    end else begin
      m_clamp = req_i.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      key_q    <= '0;
      m_q      <= '0;
      acc_q    <= '0;
      quo_q    <= '0;
      done_q   <= 1'b0;
      bucket_q <= '0;
    end else begin
      done_q <= (state_q == StBucket);
      unique case (state_q)
        StIdle: begin
          if (req_i.start) begin
            key_q   <= req_i.key;
            m_q     <= m_clamp;
            state_q <= StSumHi;
          end
        end
        StSumHi: begin
          acc_q   <= prod[OpW-1:0];
          state_q <= StSumLo;
        end
        StSumLo: begin
          acc_q   <= acc_q + prod[OpW-1:0];
          state_q <= StQuot;
        end
        StQuot: begin
          quo_q   <= prod[cht_pkg::SumShift +: QuoW];
          state_q <= StFrac;
        end
        StFrac: begin
          // remainder is the fraction; now scale it by m
          acc_q   <= acc_q - prod[OpW-1:0];
          state_q <= StScale;
        end
        StScale: begin
          acc_q   <= prod[OpW-1:0];
          state_q <= StBucket;
        end
        StBucket: begin
          bucket_q <= prod[cht_pkg::ScaleShift +: BucketW];
          state_q  <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.bucket = bucket_q;

endmodule

// File: rtl/core/chained_hash_table_top.sv
// chained hash table with a fixed node pool
// input stream: one word per command; tuser carries the command (clear, insert,
// search), tdata carries key and payload. output stream: exactly one word per
// command; tuser carries the status (ok / not found / pool full), tdata carries
// the found payload and the bucket index.
// the bucket is floor(m * frac(key * 0.618033)) computed exactly by one shared
// 32x32 multiplier in six passes (key product in two halves, reciprocal
// quotient, multiply-subtract, scale by m, reciprocal quotient).
// each command waits for the hash result; an insert then writes its node, and a
// search of a used bucket reads the bucket head and then walks the chain. the
// block is ready again the cycle after the result is loaded, and it accepts no
// new command before the result of the last one is loaded.
// the chain walk is bound by the registered read of the node memory: one node
// per cycle.
// a finished result sits in the output register; the next command is accepted
// while it waits. a stalled receiver only holds the block once a second result
// is ready.
// reset empties all buckets and the pool and sets bucket_count to 40; no
// memory clearing pass is needed. bucket_count is written via cfg_we_i; the user
// must write it only while the block is idle, which the block does not enforce.
module chained_hash_table_top #(
  parameter int unsigned POOL_NODES = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration: bucket_count
  input  logic                         cfg_we_i,
  input  logic [cht_pkg::CountW-1:0]   cfg_wdata_i,
  // command stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [cht_pkg::SDataW-1:0]   s_axis_tdata,   // key[19:0], payload[51:20]
  input  logic [cht_pkg::CmdW-1:0]     s_axis_tuser,   // command[1:0]
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [cht_pkg::MDataW-1:0]   m_axis_tdata,   // found_payload[31:0], bucket[37:32]
  output logic [cht_pkg::StatusW-1:0]  m_axis_tuser    // status[1:0]
);

  localparam int unsigned KeyW    = cht_pkg::KeyW;
  localparam int unsigned DataW   = cht_pkg::DataW;
  localparam int unsigned BucketW = cht_pkg::BucketW;
  localparam int unsigned IdxW    = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int unsigned FreeW   = $clog2(POOL_NODES + 1);
  localparam int unsigned LinkW   = IdxW + 1;
  localparam int unsigned NodeW   = KeyW + DataW + LinkW;
  localparam int unsigned PadW    = cht_pkg::MDataW - DataW - BucketW;

  typedef struct packed {
    logic            valid;  // low marks end of chain
    logic [IdxW-1:0] idx;
  } link_t;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [DataW-1:0] data;
    link_t            link;
  } node_t;

  typedef enum logic [2:0] {
    StIdle,
    StHash,
    StIns,
    StHead,
    StChk,
    StDone
  } state_e;

  state_e                     state_q;
  logic [cht_pkg::CmdW-1:0]   cmd_q;
  logic [KeyW-1:0]            key_q;
  logic [DataW-1:0]           payload_q;
  logic [BucketW-1:0]         bucket_q;
  logic [cht_pkg::MaxBuckets-1:0] used_q;
  logic [FreeW-1:0]           free_q;
  cht_pkg::status_e           status_q;
  logic [DataW-1:0]           found_q;
  logic [cht_pkg::CountW-1:0] count_q;

  logic                       m_valid_q;
  cht_pkg::status_e           m_status_q;
  logic [DataW-1:0]           m_payload_q;
  logic [BucketW-1:0]         m_bucket_q;

  logic               s_accept;
  logic               out_load;
  cht_pkg::hash_req_t hash_req;
  cht_pkg::hash_rsp_t hash_rsp;
  logic [IdxW-1:0]    head_rdata;
  logic               head_we;
  node_t              node_rdata;
  node_t              node_wdata;
  logic [IdxW-1:0]    node_raddr;
  logic [IdxW-1:0]    free_idx;

  assign s_axis_tready = (state_q == StIdle);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // result goes to the output register once it is free or being taken
  assign out_load = (state_q == StDone) && (!m_valid_q || m_axis_tready);

  // hash request goes out straight from the input word
  assign hash_req.start = s_accept;
  assign hash_req.key   = s_axis_tdata[KeyW-1:0];
  assign hash_req.count = count_q;

  cht_hash_unit u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hash_req),
    .rsp_o  (hash_rsp)
  );

  assign free_idx = free_q[IdxW-1:0];
  assign head_we  = (state_q == StIns);

  // bucket head memory, read with the fresh bucket as the hash completes
  cht_ram #(
    .WIDTH (IdxW),
    .DEPTH (cht_pkg::MaxBuckets)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (bucket_q),
    .wdata_i (free_idx),
    .raddr_i (hash_rsp.bucket),
    .rdata_o (head_rdata)
  );

  // new node links to the old head if the bucket was in use
  assign node_wdata.key        = key_q;
  assign node_wdata.data       = payload_q;
  assign node_wdata.link.valid = used_q[bucket_q];
  assign node_wdata.link.idx   = head_rdata;

  // chain walk: first node from the head, then follow the link just read
  assign node_raddr = (state_q == StHead) ? head_rdata : node_rdata.link.idx;

  cht_ram #(
    .WIDTH (NodeW),
    .DEPTH (POOL_NODES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (free_idx),
    .wdata_i (node_wdata),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  // bucket_count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= cht_pkg::CountReset;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // command sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cmd_q       <= '0;
      key_q       <= '0;
      payload_q   <= '0;
      bucket_q    <= '0;
      used_q      <= '0;
      free_q      <= '0;
      status_q    <= cht_pkg::StatusOk;
      found_q     <= '0;
      m_valid_q   <= 1'b0;
      m_status_q  <= cht_pkg::StatusOk;
      m_payload_q <= '0;
      m_bucket_q  <= '0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (s_accept) begin
            cmd_q     <= s_axis_tuser;
            key_q     <= s_axis_tdata[KeyW-1:0];
            payload_q <= s_axis_tdata[KeyW +: DataW];
            state_q   <= StHash;
          end
        end
        StHash: begin
          if (hash_rsp.done) begin
            bucket_q <= hash_rsp.bucket;
            found_q  <= '0;
            status_q <= cht_pkg::StatusOk;
            unique case (cmd_q)
              cht_pkg::CmdClear: begin
                used_q  <= '0;
                free_q  <= '0;
                state_q <= StDone;
              end
              cht_pkg::CmdInsert: begin
                if (free_q == FreeW'(POOL_NODES)) begin
                  status_q <= cht_pkg::StatusFull;
                  state_q  <= StDone;
                end else begin
                  state_q <= StIns;
                end
              end
              cht_pkg::CmdSearch: begin
                if (!used_q[hash_rsp.bucket]) begin
                  status_q <= cht_pkg::StatusMiss;
                  state_q  <= StDone;
                end else begin
                  state_q <= StHead;
                end
              end
              default: begin
                state_q <= StDone;
              end
            endcase
          end
        end
        StIns: begin
          used_q[bucket_q] <= 1'b1;
          free_q           <= free_q + FreeW'(1);
          state_q          <= StDone;
        end
        StHead: begin
          state_q <= StChk;
        end
        StChk: begin
          if (node_rdata.key == key_q) begin
            found_q <= node_rdata.data;
            state_q <= StDone;
          end else if (!node_rdata.link.valid) begin
            status_q <= cht_pkg::StatusMiss;
            state_q  <= StDone;
          end
        end
        StDone: begin
          if (out_load) begin
            m_status_q  <= status_q;
            m_payload_q <= found_q;
            m_bucket_q  <= bucket_q;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, m_bucket_q, m_payload_q};
  assign m_axis_tuser  = m_status_q;

endmodule

// File: rtl/core/cht_checker.sv
module cht_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [cht_pkg::MDataW-1:0]  m_axis_tdata,
  input logic [cht_pkg::StatusW-1:0] m_axis_tuser
);

  // result word holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // the block is busy after every accept, so no back to back accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("command accepted while busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == cht_pkg::StatusOk ||
                       m_axis_tuser == cht_pkg::StatusMiss ||
                       m_axis_tuser == cht_pkg::StatusFull))
    else $error("unknown status code");

  // misses and full inserts report a zero payload
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != cht_pkg::StatusOk)
      |-> (m_axis_tdata[cht_pkg::DataW-1:0] == '0))
    else $error("nonzero payload on failed command");

endmodule

bind chained_hash_table_top cht_checker u_cht_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
